// File: design/sadf_pkg.sv
// Shared constants, types and conversion tables of the sRGB area-filter downsampler.
package sadf_pkg;

  localparam int MaxSide     = 4096;
  localparam int LinFracBits = 16;

  localparam int RawW     = 13;
  localparam int OutPosW  = 11;
  localparam int CodeW    = 8;
  localparam int HalfSide = MaxSide / 2;
  localparam int SideW    = $clog2(MaxSide + 1);
  localparam int HalfW    = $clog2(HalfSide + 1);
  localparam int PosW     = $clog2(MaxSide);
  localparam int ColW     = (HalfSide > 1) ? $clog2(HalfSide) : 1;
  localparam int LinW     = LinFracBits + 1;
  localparam int WtW      = $clog2(HalfSide * HalfSide + 1);
  localparam int ProdW    = LinW + WtW;
  localparam int SumW     = LinFracBits + 2 * $clog2(MaxSide) + 1;
  localparam int NW       = $clog2(MaxSide * MaxSide + 1);
  localparam int CmpW     = SumW + 2;
  localparam int AddrW    = ColW + 1;
  localparam int MemDepth = 2 ** AddrW;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int StepW    = 3;

  typedef enum logic [1:0] {OpRight, OpBelow, OpDiag, OpHome} acc_op_e;
  typedef enum logic [1:0] {AccClear, AccIdle, AccRead, AccWrite} acc_state_e;
  typedef enum logic [1:0] {EncIdle, EncSearch, EncHold} enc_state_e;

  typedef logic [3:0][SumW-1:0] sum4_t;

  typedef struct packed {
    logic [SideW-1:0] w;
    logic [SideW-1:0] h;
    logic [HalfW-1:0] wo;
    logic [HalfW-1:0] ho;
    logic             srgb;
    logic [NW-1:0]    n;
  } cfg_t;

  // One source pixel as seen by the accumulator: channel values (linear for sRGB
  // color), the weights of the four output cells it may touch, and where it lands.
  typedef struct packed {
    logic [3:0][LinW-1:0] v;
    logic [3:0][WtW-1:0]  wt;
    logic [ColW-1:0]      k;
    logic [ColW-1:0]      j;
    logic                 finish;
    logic                 done;
  } tok_t;

  typedef struct packed {
    sum4_t           sum;
    logic [ColW-1:0] k;
    logic [ColW-1:0] j;
    logic            done;
  } job_t;

  localparam logic [63:0] Q32Max    = 64'hFFFF_FFFF;
  localparam logic [63:0] LinDiv255 = 64'd255 * 64'd323;
  localparam logic [63:0] LinDiv510 = 64'd510 * 64'd323;
  localparam logic [63:0] XDiv255   = 64'd255 * 64'd211;
  localparam logic [63:0] XDiv510   = 64'd510 * 64'd211;
  localparam int          FixShift  = 32 - LinFracBits;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  // Linear light of num/255 (half low) or num/510 (half high) in Q0.32.
  function automatic logic [63:0] lin_q32(input logic [63:0] num, input logic half);
    logic [63:0] den, x, x2, lo, hi, mid, p;
    den = half ? 64'd510 : 64'd255;
    lo  = '0;
    hi  = Q32Max;
    if (num * 64'd20000 <= den * 64'd809) begin
      return half ? ((num * 64'd25) << 32) / LinDiv510 : ((num * 64'd25) << 32) / LinDiv255;
    end
    x = half ? ((64'd200 * num + 64'd11 * den) << 32) / XDiv510
             : ((64'd200 * num + 64'd11 * den) << 32) / XDiv255;
    if (x > Q32Max) x = Q32Max;
    x2 = qmul(x, x);
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        p   = qmul(qmul(qmul(qmul(mid, mid), mid), mid), mid);
        if (p <= x2) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return qmul(x2, lo);
  endfunction

  function automatic logic [63:0] to_fixed(input logic [63:0] v);
    return (v + (64'd1 << (FixShift - 1))) >> FixShift;
  endfunction

  typedef logic [LinW-1:0] lin_tab_t [256];

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int c = 0; c < 256; c++) t[c] = LinW'(to_fixed(lin_q32(64'(c), 1'b0)));
    return t;
  endfunction

  function automatic lin_tab_t build_thr();
    lin_tab_t t;
    t[0] = '0;
    for (int c = 1; c < 256; c++) t[c] = LinW'(to_fixed(lin_q32(64'(2 * c - 1), 1'b1)));
    return t;
  endfunction

  localparam lin_tab_t LinTable = build_lin();
  localparam lin_tab_t ThrTable = build_thr();

endpackage

// File: design/sadf_if.sv
// Pixel input and result output channel interfaces.
interface sadf_pix_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface sadf_res_if import sadf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CodeW-1:0]   red_out;
  logic [CodeW-1:0]   green_out;
  logic [CodeW-1:0]   blue_out;
  logic [CodeW-1:0]   alpha_out;
  logic [OutPosW-1:0] out_x;
  logic [OutPosW-1:0] out_y;
  logic               level_done;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, out_x, out_y,
                  level_done, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, out_x, out_y,
                level_done, output ready);
endinterface

// File: design/sadf_front.sv
// Front end: takes source pixels, tracks positions and builds accumulator tokens.
module sadf_front import sadf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         restart_i,
  input  cfg_t         cfg_i,
  input  logic         hold_i,
  sadf_pix_if.sink     pix_in,
  input  logic         full_i,
  output logic         push_o,
  output tok_t         tok_o
);

  logic [PosW-1:0]  sc_q, sc_d, sr_q, sr_d, rx_q, rx_d, ry_q, ry_d;
  logic [ColW-1:0]  k_q, k_d, j_q, j_d;
  logic [SideW:0]   sx, sy;
  logic             cross_x, cross_y, last_col, last_row, accept;
  logic [HalfW-1:0] wx0, wx1, wy0, wy1;
  logic [2*HalfW-1:0] p00, p10, p01, p11;
  logic [3:0][CodeW-1:0] codes;

  assign pix_in.ready = !full_i && !hold_i;
  assign accept       = pix_in.valid && pix_in.ready;
  assign push_o       = accept;

  // Positions are kept in units scaled by the result size, so the pixel's
  // extent relative to its output cell is a remainder against the side.
  always_comb begin
    sx      = (SideW + 1)'(rx_q) + (SideW + 1)'(cfg_i.wo);
    sy      = (SideW + 1)'(ry_q) + (SideW + 1)'(cfg_i.ho);
    cross_x = sx >= (SideW + 1)'(cfg_i.w);
    cross_y = sy >= (SideW + 1)'(cfg_i.h);
    wx0 = cross_x ? HalfW'((SideW + 1)'(cfg_i.w) - (SideW + 1)'(rx_q)) : cfg_i.wo;
    wx1 = cross_x ? HalfW'(sx - (SideW + 1)'(cfg_i.w)) : '0;
    wy0 = cross_y ? HalfW'((SideW + 1)'(cfg_i.h) - (SideW + 1)'(ry_q)) : cfg_i.ho;
    wy1 = cross_y ? HalfW'(sy - (SideW + 1)'(cfg_i.h)) : '0;
    p00 = wx0 * wy0;
    p10 = wx1 * wy0;
    p01 = wx0 * wy1;
    p11 = wx1 * wy1;
    last_col = sc_q == PosW'(cfg_i.w - SideW'(1));
    last_row = sr_q == PosW'(cfg_i.h - SideW'(1));

    codes = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
    for (int ch = 0; ch < 4; ch++) begin
      tok_o.v[ch] = (cfg_i.srgb && ch < 3) ? LinTable[codes[ch]] : LinW'(codes[ch]);
    end
    tok_o.wt[OpRight] = WtW'(p10);
    tok_o.wt[OpBelow] = WtW'(p01);
    tok_o.wt[OpDiag]  = WtW'(p11);
    tok_o.wt[OpHome]  = WtW'(p00);
    tok_o.k      = k_q;
    tok_o.j      = j_q;
    tok_o.finish = cross_x && cross_y;
    tok_o.done   = cross_x && cross_y && k_q == ColW'(cfg_i.wo - HalfW'(1)) &&
                   j_q == ColW'(cfg_i.ho - HalfW'(1));

    sc_d = sc_q; sr_d = sr_q; rx_d = rx_q; ry_d = ry_q; k_d = k_q; j_d = j_q;
    if (accept) begin
      if (last_col) begin
        sc_d = '0; rx_d = '0; k_d = '0;
        if (last_row) begin
          sr_d = '0; ry_d = '0; j_d = '0;
        end else begin
          sr_d = sr_q + PosW'(1);
          ry_d = cross_y ? PosW'(sy - (SideW + 1)'(cfg_i.h)) : PosW'(sy);
          j_d  = j_q + ColW'(cross_y);
        end
      end else begin
        sc_d = sc_q + PosW'(1);
        rx_d = cross_x ? PosW'(sx - (SideW + 1)'(cfg_i.w)) : PosW'(sx);
        k_d  = k_q + ColW'(cross_x);
      end
    end
    if (restart_i) begin
      sc_d = '0; sr_d = '0; rx_d = '0; ry_d = '0; k_d = '0; j_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0; sr_q <= '0; rx_q <= '0; ry_q <= '0; k_q <= '0; j_q <= '0;
    end else begin
      sc_q <= sc_d; sr_q <= sr_d; rx_q <= rx_d; ry_q <= ry_d; k_q <= k_d; j_q <= j_d;
    end
  end

endmodule

// File: design/sadf_queue.sv
// Small token queue between the front end and the accumulator.
module sadf_queue import sadf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic flush_i,
  input  logic push_i,
  input  tok_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output tok_t head_o,
  output logic empty_o
);

  tok_t             slots_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPtrW + 1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i);
    rd_d  = rd_q + QPtrW'(pop_i);
    cnt_d = cnt_q + (QPtrW + 1)'(push_i) - (QPtrW + 1)'(pop_i);
    if (flush_i) begin
      wr_d = '0; rd_d = '0; cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= push_data_i;
  end

endmodule

// File: design/sadf_accum.sv
// Accumulator: read-modify-write of the two-row column sum memory.
module sadf_accum import sadf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic restart_i,
  input  tok_t tok_i,
  input  logic tok_valid_i,
  output logic tok_pop_o,
  output logic clearing_o,
  output job_t job_o,
  output logic job_valid_o,
  input  logic job_ready_i
);

  sum4_t mem [MemDepth];

  acc_state_e            state_q, state_d;
  acc_op_e               op_q, op_d;
  tok_t                  tok_q, tok_d;
  logic [AddrW-1:0]      clr_q, clr_d;
  logic [3:0][ProdW-1:0] prod_q;
  sum4_t                 rdata_q, sum, wdata;
  logic [AddrW-1:0]      addr, waddr;
  logic                  dx, dy, fin, proceed, we, re;
  logic [2:0]            allow_after;

  function automatic acc_op_e pick_op(input logic [3:0][WtW-1:0] wt, input logic [2:0] allow);
    acc_op_e r;
    r = OpHome;
    for (int i = 2; i >= 0; i--) begin
      if (allow[i] && wt[i] != '0) r = acc_op_e'(2'(i));
    end
    return r;
  endfunction

  always_comb begin
    dx   = op_q == OpRight || op_q == OpDiag;
    dy   = op_q == OpBelow || op_q == OpDiag;
    addr = {tok_q.j[0] ^ dy, tok_q.k + ColW'(dx)};
    for (int ch = 0; ch < 4; ch++) sum[ch] = rdata_q[ch] + SumW'(prod_q[ch]);
    case (op_q)
      OpRight: allow_after = 3'b110;
      OpBelow: allow_after = 3'b100;
      default: allow_after = 3'b000;
    endcase
    fin         = op_q == OpHome && tok_q.finish;
    proceed     = !fin || job_ready_i;
    job_valid_o = state_q == AccWrite && fin;
    job_o.sum   = sum;
    job_o.k     = tok_q.k;
    job_o.j     = tok_q.j;
    job_o.done  = tok_q.done;
    clearing_o  = state_q == AccClear;

    state_d = state_q; op_d = op_q; tok_d = tok_q; clr_d = clr_q;
    tok_pop_o = 1'b0; we = 1'b0; re = 1'b0; waddr = addr; wdata = sum;
    case (state_q)
      AccClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MemDepth - 1)) state_d = AccIdle;
      end
      AccIdle: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          tok_d     = tok_i;
          op_d      = pick_op(tok_i.wt, 3'b111);
          state_d   = AccRead;
        end
      end
      AccRead: begin
        re      = 1'b1;
        state_d = AccWrite;
      end
      AccWrite: begin
        if (proceed) begin
          we    = 1'b1;
          wdata = fin ? '0 : sum;
          if (op_q != OpHome) begin
            op_d    = pick_op(tok_q.wt, allow_after);
            state_d = AccRead;
          end else if (tok_valid_i) begin
            tok_pop_o = 1'b1;
            tok_d     = tok_i;
            op_d      = pick_op(tok_i.wt, 3'b111);
            state_d   = AccRead;
          end else begin
            state_d = AccIdle;
          end
        end
      end
      default: state_d = AccClear;
    endcase
    if (restart_i) begin
      state_d   = AccClear;
      clr_d     = '0;
      tok_pop_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AccClear;
      clr_q   <= '0;
      op_q    <= OpHome;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (state_q == AccRead) begin
      for (int ch = 0; ch < 4; ch++) prod_q[ch] <= tok_q.v[ch] * tok_q.wt[op_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[addr];
  end

endmodule

// File: design/sadf_encode.sv
// Encoder: turns finished area sums into 8-bit codes by an 8-step search.
module sadf_encode import sadf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  sadf_res_if.source res_out
);

  enc_state_e             state_q, state_d;
  job_t                   job_q;
  logic [3:0][CodeW-1:0]  code_q, code_d, try_code;
  logic [StepW-1:0]       step_q, step_d;
  logic                   res_valid_q, res_valid_d, load_out;
  logic [3:0][CodeW-1:0]  res_code_q;
  logic [OutPosW-1:0]     res_x_q, res_y_q;
  logic                   res_done_q;
  logic [LinW-1:0]        mul_a   [4];
  logic [LinW+NW-1:0]     mul_p   [4];
  logic [CmpW-1:0]        rhs     [4];
  logic                   color   [4];

  assign job_ready_o      = state_q == EncIdle;
  assign res_out.valid    = res_valid_q;
  assign res_out.red_out  = res_code_q[0];
  assign res_out.green_out = res_code_q[1];
  assign res_out.blue_out = res_code_q[2];
  assign res_out.alpha_out = res_code_q[3];
  assign res_out.out_x    = res_x_q;
  assign res_out.out_y    = res_y_q;
  assign res_out.level_done = res_done_q;

  // Each step tries one more code bit: a color code in linear light tests
  // the threshold table, a raw code tests the rounded quotient.
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      color[ch]    = cfg_i.srgb && ch < 3;
      try_code[ch] = code_q[ch] | (CodeW'(1) << step_q);
      mul_a[ch]    = color[ch] ? ThrTable[try_code[ch]] : LinW'({try_code[ch], 1'b0});
      mul_p[ch]    = mul_a[ch] * cfg_i.n;
      rhs[ch]      = color[ch] ? CmpW'(job_q.sum[ch])
                               : (CmpW'(job_q.sum[ch]) << 1) + CmpW'(cfg_i.n);
    end

    state_d = state_q; code_d = code_q; step_d = step_q; load_out = 1'b0;
    res_valid_d = res_valid_q && !res_out.ready;
    case (state_q)
      EncIdle: begin
        if (job_valid_i) begin
          code_d  = '0;
          step_d  = StepW'(CodeW - 1);
          state_d = EncSearch;
        end
      end
      EncSearch: begin
        for (int ch = 0; ch < 4; ch++) begin
          if (CmpW'(mul_p[ch]) <= rhs[ch]) code_d[ch] = try_code[ch];
        end
        step_d = step_q - StepW'(1);
        if (step_q == '0) state_d = EncHold;
      end
      EncHold: begin
        if (!res_valid_q || res_out.ready) begin
          load_out    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = EncIdle;
        end
      end
      default: state_d = EncIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EncIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    step_q <= step_d;
    if (state_q == EncIdle && job_valid_i) job_q <= job_i;
    if (load_out) begin
      res_code_q <= code_q;
      res_x_q    <= OutPosW'(job_q.k);
      res_y_q    <= OutPosW'(job_q.j);
      res_done_q <= job_q.done;
    end
  end

endmodule

// File: design/srgb_area_filter_downsample_core.sv
// Top level of the sRGB-correct area-filter mip downsampler.
// Source RGBA8 pixels of one level stream in raster order on pix_i and the
// next level comes out on res_o, one transaction per finished output pixel,
// with its position and a flag on the last pixel of the level. Each output
// is the exact area-weighted mean of the source pixels it covers; with
// the sRGB register set, red, green and blue are averaged in linear light and
// re-encoded, while alpha is always averaged as is. Every update of an output
// cell is one read and one write of the column sum memory, in the AccRead and
// AccWrite states, and a source pixel needs one update for each output cell it
// touches: one for most pixels, up to four where a pixel straddles an output
// column and row boundary (odd source sides). Finished sums are encoded by a
// separate search unit that runs alongside the accumulator and takes one sum
// at a time, so where every pixel finishes an output (a 1x1 source) or about
// every second pixel does (a 1-pixel-wide or 1-pixel-high source), the
// encoder sets the pace. After reset and after every register write the sum
// memory is cleared in the AccClear state, during which no pixel is taken;
// any register write restarts the level.
module srgb_area_filter_downsample_core import sadf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sadf_pix_if.sink    pix_i,
  sadf_res_if.source  res_o
);

  typedef enum logic [1:0] {RegWidth, RegHeight, RegSrgb} reg_idx_e;

  logic [RawW-1:0] width_q, height_q;
  logic            srgb_q;
  cfg_t            cfg_q;
  logic            wr_en, restart;
  logic [1:0]      reg_idx;

  tok_t  push_tok, head_tok;
  logic  push, q_full, q_empty, pop, clearing;
  job_t  job;
  logic  job_valid, job_ready;

  function automatic logic [SideW-1:0] eff_side(input logic [RawW-1:0] raw);
    if (raw == '0) return SideW'(1);
    if ((SideW + RawW)'(raw) > (SideW + RawW)'(MaxSide)) return SideW'(MaxSide);
    return SideW'(raw);
  endfunction

  function automatic logic [HalfW-1:0] half_side(input logic [SideW-1:0] v);
    return (v >= SideW'(2)) ? HalfW'(v >> 1) : HalfW'(1);
  endfunction

  // APB register file: writes land on the access phase, reads return the
  // raw register contents.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (reg_idx)
      RegWidth: begin
        restart = wr_en;
        prdata  = 32'(width_q);
      end
      RegHeight: begin
        restart = wr_en;
        prdata  = 32'(height_q);
      end
      RegSrgb: begin
        restart = wr_en;
        prdata  = 32'(srgb_q);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RawW'(1);
      height_q <= RawW'(1);
      srgb_q   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        RegWidth:  width_q  <= pwdata[RawW-1:0];
        RegHeight: height_q <= pwdata[RawW-1:0];
        RegSrgb:   srgb_q   <= pwdata[0];
        default:   srgb_q   <= srgb_q;
      endcase
    end
  end

  // Derived geometry is registered; the pixel count is taken from the registered
  // sides and follows them in the cycle after, well inside the clearing pass that any register write starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.w    <= SideW'(1);
      cfg_q.h    <= SideW'(1);
      cfg_q.wo   <= HalfW'(1);
      cfg_q.ho   <= HalfW'(1);
      cfg_q.srgb <= 1'b0;
      cfg_q.n    <= NW'(1);
    end else begin
      cfg_q.w    <= eff_side(width_q);
      cfg_q.h    <= eff_side(height_q);
      cfg_q.wo   <= half_side(eff_side(width_q));
      cfg_q.ho   <= half_side(eff_side(height_q));
      cfg_q.srgb <= srgb_q;
      cfg_q.n    <= NW'(cfg_q.w) * NW'(cfg_q.h);
    end
  end

  sadf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .cfg_i     (cfg_q),
    .hold_i    (clearing),
    .pix_in    (pix_i),
    .full_i    (q_full),
    .push_o    (push),
    .tok_o     (push_tok)
  );

  sadf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (restart),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head_tok),
    .empty_o     (q_empty)
  );

  sadf_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .tok_i       (head_tok),
    .tok_valid_i (!q_empty),
    .tok_pop_o   (pop),
    .clearing_o  (clearing),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  sadf_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .res_out     (res_o)
  );

endmodule
